// ===== hw/rtl/temp_press_hum_compensation_defines.svh =====
// assertion macros used by the asserting file temp_press_hum_compensation.sv
`ifndef TEMP_PRESS_HUM_COMPENSATION_DEFINES_SVH
`define TEMP_PRESS_HUM_COMPENSATION_DEFINES_SVH

`ifndef SYNTHESIS
`define TPH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tph assertion failed");
`define TPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tph assertion failed");
`else
`define TPH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/tph_pkg.sv =====
package tph_pkg;

  localparam int unsigned W = 64;
  localparam int unsigned DIG_W = 16;
  localparam int unsigned MUL_DIGITS = W / DIG_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_DIGITS);
  localparam int unsigned DIV_CNT_W = $clog2(W);

  localparam logic [23:0] SKIP_TEMP = 24'h800000;
  localparam logic [15:0] SKIP_HUM = 16'h8000;
  localparam logic [31:0] HUM_MAX = 32'd419430400;

  typedef enum logic [2:0] {
    CFG_TEMP    = 3'd0,
    CFG_PRESS_A = 3'd1,
    CFG_PRESS_B = 3'd2,
    CFG_P9_HUM  = 3'd3,
    CFG_HUM_B   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PFIN,
    ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    STP_T1, STP_T2, STP_T3, STP_T4,
    STP_P1, STP_P2, STP_P3, STP_P4, STP_P5, STP_P6, STP_P7, STP_P8, STP_P9, STP_P10,
    STP_H1, STP_H2, STP_H3, STP_H4, STP_H5, STP_H6, STP_H7, STP_H8
  } step_t;

  typedef struct packed {
    logic         start;
    logic [W-1:0] a;
    logic [W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         start;
    logic [W-1:0] num;
    logic [W-1:0] den;
  } div_req_t;

  function automatic logic [W-1:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [W-1:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

endpackage

// ===== hw/rtl/temp_press_hum_compensation.sv =====
// channel  direction  handshake             payload
// in_      slave      in_tvalid/in_tready   raw temperature, pressure, humidity
// out_     master     out_tvalid/out_tready compensated values, valid flags in tuser
// cfg_     slave      cfg_valid/cfg_ready   register index and data
//
// one shared 64-bit multiplier (one 16-bit digit a cycle) and a
// restoring divider do all the arithmetic under a step sequencer
// a full sample takes about 22 multiplies plus one divide, fewer when
// temperature or humidity is skipped; in_tready is low meanwhile
// the output register lets the next sample start while a result waits
// synchronous active-low reset clears control, coefficients and fine temperature
module temp_press_hum_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // raw_temperature[23:0], raw_pressure[47:24], raw_humidity[63:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // temp_centi_degc[19:0], press_q24_8_pa[51:20], hum_q7_10_rh[68:52], zero
  output logic [2:0]  out_tuser,  // temp_valid[0], press_valid[1], hum_valid[2]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import tph_pkg::*;

  `include "temp_press_hum_compensation_defines.svh"

  state_t       st_r, st_nxt;
  step_t        stp_r, stp_nxt;
  step_t        hum_stp;
  state_t       hum_st;

  logic [47:0]  tc_r;
  logic [63:0]  pa_r;
  logic [63:0]  pb_r;
  logic [47:0]  ph_r;
  logic [31:0]  hb_r;
  logic [31:0]  fine_r;

  logic [23:0]  rt_r;
  logic [23:0]  rp_r;
  logic [15:0]  rh_r;
  logic [W-1:0] ra_r, rb_r, rc_r, rd_r, re_r, rq_r;

  logic [19:0]  temp_o_r;
  logic [31:0]  press_o_r;
  logic [16:0]  hum_o_r;
  logic         tv_r, pv_r, hv_r;
  logic         out_valid_r;
  logic [71:0]  out_data_r;
  logic [2:0]   out_user_r;

  mul_req_t     mreq;
  div_req_t     dreq;
  logic         mul_done;
  logic [W-1:0] mul_prod;
  logic         div_done;
  logic [W-1:0] div_quo;

  logic         in_acc;
  logic         out_free;
  logic [31:0]  m32;
  logic [W-1:0] a64;
  logic [31:0]  v32;
  logic [W-1:0] pdiff;
  logic [W-1:0] p_den;
  logic [31:0]  tc32;
  logic [31:0]  hum_v;
  logic [31:0]  hx_sum;
  logic [31:0]  hfloor;
  logic [31:0]  s32;
  logic [W-1:0] q13;

  tph_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .done (mul_done),
    .prod (mul_prod)
  );

  tph_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .done (div_done),
    .quo  (div_quo)
  );

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // shared operand terms
  assign m32   = mul_prod[31:0];
  assign a64   = sx32(fine_r) - W'(128000);
  assign v32   = fine_r - 32'd76800;
  assign pdiff = W'(1048576) - {44'b0, rp_r[23:4]};
  assign p_den = 64'($signed(mul_prod) >>> 33);
  assign tc32  = 32'($signed(m32 + 32'd128) >>> 8);
  assign hx_sum = {2'b0, rh_r, 14'b0} - {hb_r[11:0], 20'b0} - m32 + 32'd16384;
  assign hfloor = rc_r[31:0] - 32'($signed(m32) >>> 4);
  assign hum_v  = hfloor[31] ? 32'd0 : ((hfloor > HUM_MAX) ? HUM_MAX : hfloor);
  assign s32    = 32'($signed(rc_r[31:0]) >>> 15);
  assign q13    = 64'($signed(rq_r) >>> 13);

  // humidity entry point after temperature and pressure
  always_comb begin
    if (rh_r != SKIP_HUM) begin
      hum_stp = STP_H1;
      hum_st  = ST_ISSUE;
    end else begin
      hum_stp = STP_H1;
      hum_st  = ST_OUT;
    end
  end

  // next state and step
  always_comb begin
    st_nxt  = st_r;
    stp_nxt = stp_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tdata[23:0] != SKIP_TEMP) begin
            stp_nxt = STP_T1;
            st_nxt  = ST_ISSUE;
          end else if (in_tdata[63:48] != SKIP_HUM) begin
            stp_nxt = STP_H1;
            st_nxt  = ST_ISSUE;
          end else begin
            st_nxt = ST_OUT;
          end
        end
      end
      ST_ISSUE: st_nxt = ST_WAIT;
      ST_WAIT: begin
        if (mul_done) begin
          unique case (stp_r)
            STP_P6: begin
              if (p_den == '0) begin
                stp_nxt = hum_stp;
                st_nxt  = hum_st;
              end else begin
                stp_nxt = STP_P7;
                st_nxt  = ST_ISSUE;
              end
            end
            STP_P7:  st_nxt = ST_DIV_GO;
            STP_P10: st_nxt = ST_PFIN;
            STP_H8:  st_nxt = ST_OUT;
            default: begin
              stp_nxt = step_t'(stp_r + 5'd1);
              st_nxt  = ST_ISSUE;
            end
          endcase
        end
      end
      ST_DIV_GO: st_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          stp_nxt = STP_P8;
          st_nxt  = ST_ISSUE;
        end
      end
      ST_PFIN: begin
        stp_nxt = hum_stp;
        st_nxt  = hum_st;
      end
      ST_OUT: begin
        if (out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // unit requests and operand selection
  always_comb begin
    in_tready  = (st_r == ST_IDLE);
    mreq.start = (st_r == ST_ISSUE);
    mreq.a     = '0;
    mreq.b     = '0;
    dreq.start = (st_r == ST_DIV_GO);
    dreq.num   = rd_r;
    dreq.den   = rc_r;
    case (stp_r)
      STP_T1: begin
        mreq.a = sx32({15'b0, rt_r[23:7]} - {15'b0, tc_r[15:0], 1'b0});
        mreq.b = sx16(tc_r[31:16]);
      end
      STP_T2: begin
        mreq.a = sx32({16'b0, rt_r[23:8]} - {16'b0, tc_r[15:0]});
        mreq.b = sx32({16'b0, rt_r[23:8]} - {16'b0, tc_r[15:0]});
      end
      STP_T3: begin
        mreq.a = sx32(rb_r[31:0]);
        mreq.b = sx16(tc_r[47:32]);
      end
      STP_T4: begin
        mreq.a = sx32(fine_r);
        mreq.b = W'(5);
      end
      STP_P1: begin
        mreq.a = a64;
        mreq.b = a64;
      end
      STP_P2: begin
        mreq.a = ra_r;
        mreq.b = sx16(pb_r[31:16]);
      end
      STP_P3: begin
        mreq.a = a64;
        mreq.b = sx16(pb_r[15:0]);
      end
      STP_P4: begin
        mreq.a = ra_r;
        mreq.b = sx16(pa_r[47:32]);
      end
      STP_P5: begin
        mreq.a = a64;
        mreq.b = sx16(pa_r[31:16]);
      end
      STP_P6: begin
        mreq.a = rc_r;
        mreq.b = {48'b0, pa_r[15:0]};
      end
      STP_P7: begin
        mreq.a = rd_r;
        mreq.b = W'(3125);
      end
      STP_P8: begin
        mreq.a = q13;
        mreq.b = q13;
      end
      STP_P9: begin
        mreq.a = sx16(ph_r[15:0]);
        mreq.b = re_r;
      end
      STP_P10: begin
        mreq.a = sx16(pb_r[63:48]);
        mreq.b = rq_r;
      end
      STP_H1: begin
        mreq.a = sx32(sx12(hb_r[23:12]));
        mreq.b = sx32(v32);
      end
      STP_H2: begin
        mreq.a = sx32(v32);
        mreq.b = {{56{hb_r[31]}}, hb_r[31:24]};
      end
      STP_H3: begin
        mreq.a = sx32(v32);
        mreq.b = {56'b0, ph_r[47:40]};
      end
      STP_H4: begin
        mreq.a = sx32(rb_r[31:0]);
        mreq.b = sx32(rc_r[31:0]);
      end
      STP_H5: begin
        mreq.a = sx32(rb_r[31:0]);
        mreq.b = sx16(ph_r[39:24]);
      end
      STP_H6: begin
        mreq.a = sx32(ra_r[31:0]);
        mreq.b = sx32(rb_r[31:0]);
      end
      STP_H7: begin
        mreq.a = sx32(s32);
        mreq.b = sx32(s32);
      end
      STP_H8: begin
        mreq.a = sx32(rd_r[31:0]);
        mreq.b = {56'b0, ph_r[23:16]};
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  // control registers, coefficients and fine temperature
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      stp_r       <= STP_T1;
      out_valid_r <= 1'b0;
      tc_r        <= '0;
      pa_r        <= '0;
      pb_r        <= '0;
      ph_r        <= '0;
      hb_r        <= '0;
      fine_r      <= '0;
    end else begin
      st_r  <= st_nxt;
      stp_r <= stp_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TEMP:    tc_r <= cfg_data[47:0];
          CFG_PRESS_A: pa_r <= cfg_data;
          CFG_PRESS_B: pb_r <= cfg_data;
          CFG_P9_HUM:  ph_r <= cfg_data[47:0];
          CFG_HUM_B:   hb_r <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (st_r == ST_WAIT && mul_done && stp_r == STP_T3) begin
        fine_r <= ra_r[31:0] + 32'($signed(m32) >>> 14);
      end
      // output register
      if (st_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rt_r      <= in_tdata[23:0];
      rp_r      <= in_tdata[47:24];
      rh_r      <= in_tdata[63:48];
      temp_o_r  <= '0;
      press_o_r <= '0;
      hum_o_r   <= '0;
      tv_r      <= 1'b0;
      pv_r      <= 1'b0;
      hv_r      <= 1'b0;
    end
    if (st_r == ST_WAIT && mul_done) begin
      case (stp_r)
        STP_T1: ra_r <= sx32(32'($signed(m32) >>> 11));
        STP_T2: rb_r <= sx32(32'($signed(m32) >>> 12));
        STP_T4: begin
          // saturate to the 20-bit output range
          if ($signed(tc32) < -32'sd524288) begin
            temp_o_r <= 20'h80000;
          end else if ($signed(tc32) > 32'sd524287) begin
            temp_o_r <= 20'h7FFFF;
          end else begin
            temp_o_r <= tc32[19:0];
          end
          tv_r <= 1'b1;
        end
        STP_P1: ra_r <= mul_prod;
        STP_P2: rb_r <= mul_prod + {{13{pa_r[63]}}, pa_r[63:48], 35'b0};
        STP_P3: rb_r <= rb_r + {mul_prod[46:0], 17'b0};
        STP_P4: rc_r <= 64'($signed(mul_prod) >>> 8) + {16'b0, 1'b1, 47'b0};
        STP_P5: rc_r <= rc_r + {mul_prod[51:0], 12'b0};
        STP_P6: begin
          rc_r <= p_den;
          rd_r <= {pdiff[32:0], 31'b0} - rb_r;
        end
        STP_P7: rd_r <= mul_prod;
        STP_P8: re_r <= mul_prod;
        STP_P9: re_r <= rq_r + 64'($signed(mul_prod) >>> 25);
        STP_P10: re_r <= re_r + 64'($signed(mul_prod) >>> 19);
        STP_H1: ra_r <= sx32(32'($signed(hx_sum) >>> 15));
        STP_H2: rb_r <= sx32(32'($signed(m32) >>> 10));
        STP_H3: rc_r <= sx32(32'($signed(m32) >>> 11) + 32'd32768);
        STP_H4: rb_r <= sx32(32'($signed(m32) >>> 10) + 32'd2097152);
        STP_H5: rb_r <= sx32(32'($signed(m32 + 32'd8192) >>> 14));
        STP_H6: rc_r <= sx32(m32);
        STP_H7: rd_r <= sx32(32'($signed(m32) >>> 7));
        STP_H8: begin
          hum_o_r <= hum_v[28:12];
          hv_r    <= 1'b1;
        end
        default: ;
      endcase
    end
    if (st_r == ST_DIV_WAIT && div_done) begin
      rq_r <= div_quo;
    end
    // final pressure scaling
    if (st_r == ST_PFIN) begin
      press_o_r <= 32'(64'($signed(re_r) >>> 8) + {{44{pb_r[47]}}, pb_r[47:32], 4'b0});
      pv_r      <= 1'b1;
    end
    if (st_r == ST_OUT && out_free) begin
      out_data_r <= {3'b0, hum_o_r, press_o_r, temp_o_r};
      out_user_r <= {hv_r, pv_r, tv_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `TPH_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_tready)
  `TPH_ASSERT_IMPL(a_units_exclusive, clk, rst_n, mul_done, !div_done)
  `TPH_ASSERT_IMPL(a_press_needs_temp, clk, rst_n, out_tvalid && out_tuser[1], out_tuser[0])
  `TPH_ASSERT_IMPL(a_no_issue_idle, clk, rst_n, in_tready, !mul_done && !div_done)

endmodule

// ===== hw/rtl/tph_mul.sv =====
module tph_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  tph_pkg::mul_req_t   req,
  output logic                done,
  output logic [tph_pkg::W-1:0] prod
);
  import tph_pkg::*;

  logic [W-1:0]         a_r, a_nxt;
  logic [W-1:0]         b_r, b_nxt;
  logic [W-1:0]         acc_r, acc_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [W-1:0]         pp;

  // one 16-bit digit of b per cycle, low 64 bits of the product kept
  assign pp = a_r * {{(W-DIG_W){1'b0}}, b_r[DIG_W-1:0]};

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      a_nxt    = req.a;
      b_nxt    = req.b;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + pp;
      a_nxt   = a_r << DIG_W;
      b_nxt   = b_r >> DIG_W;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(MUL_DIGITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== hw/rtl/tph_div.sv =====
module tph_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tph_pkg::div_req_t     req,
  output logic                  done,
  output logic [tph_pkg::W-1:0] quo
);
  import tph_pkg::*;

  logic [W-1:0]         rem_r, rem_nxt;
  logic [W-1:0]         q_r, q_nxt;
  logic [W-1:0]         den_r, den_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 fix_r, fix_nxt;
  logic                 done_r, done_nxt;
  logic [W:0]           rem_sh;
  logic [W:0]           diff;

  // restoring step, one quotient bit per cycle
  assign rem_sh = {rem_r, q_r[W-1]};
  assign diff   = rem_sh - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    fix_nxt  = 1'b0;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      q_nxt    = req.num[W-1] ? (W'(0) - req.num) : req.num;
      den_nxt  = req.den[W-1] ? (W'(0) - req.den) : req.den;
      neg_nxt  = req.num[W-1] ^ req.den[W-1];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        fix_nxt  = 1'b1;
      end
    end else if (fix_r) begin
      // apply the quotient sign
      q_nxt    = neg_r ? (W'(0) - q_r) : q_r;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
